/* hw/rtl/ibt_pkg.sv */
// Shared types and codes for the interval booking table.
// Used by the cell, the top level and the port checker. No dependencies.
package ibt_pkg;

  typedef logic [1:0] status_t;

  localparam status_t STATUS_BOOKED  = 2'd0;
  localparam status_t STATUS_OVERLAP = 2'd1;
  localparam status_t STATUS_FULL    = 2'd2;
  localparam status_t STATUS_INVALID = 2'd3;

  // What one cell hands to the next: the scan token and the overlap flag
  // gathered so far.
  typedef struct packed {
    logic token;
    logic hit;
  } link_t;

endpackage

/* hw/rtl/interval_booking_table_top.sv */
// Interval booking table: one request at a time. For a valid interval the scan
// token ripples through all CAPACITY cells before the result is decided; an
// invalid interval skips the scan. A new request is taken only once the last result has moved to the output register.
// Synchronous reset empties the table (fill count to zero).
// Depends on ibt_pkg and ibt_cell.
module interval_booking_table_top import ibt_pkg::*; #(
  parameter int CAPACITY  = 1024,
  parameter int TIME_BITS = 30
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [TIME_BITS-1:0] start_time,
  input  logic [TIME_BITS-1:0] end_time,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 accepted,
  output status_t              status
);

  localparam int CNT_BITS = $clog2(CAPACITY + 1);
  localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(CAPACITY);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  logic [1:0]           state;
  logic [TIME_BITS-1:0] req_start;
  logic [TIME_BITS-1:0] req_end;
  logic                 inject;
  logic [CNT_BITS-1:0]  count;
  status_t              res_status;
  status_t              decision;
  logic                 scan_done;
  logic                 wr_en;
  logic                 out_free;
  link_t                links [CAPACITY+1];

  assign links[0]  = '{token: inject, hit: 1'b0};
  assign scan_done = links[CAPACITY].token;
  assign in_ready  = (state == S_IDLE);
  assign out_free  = !out_valid || out_ready;

  // Overlap takes priority over a full table.
  always_comb begin
    priority if (links[CAPACITY].hit) begin
      decision = STATUS_OVERLAP;
    end else if (count == FULL_COUNT) begin
      decision = STATUS_FULL;
    end else begin
      decision = STATUS_BOOKED;
    end
  end

  assign wr_en = (state == S_SCAN) && scan_done && (decision == STATUS_BOOKED);

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      ibt_cell #(
        .TIME_BITS (TIME_BITS),
        .CNT_BITS  (CNT_BITS),
        .INDEX     (i)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .req_start (req_start),
        .req_end   (req_end),
        .count     (count),
        .wr_en     (wr_en),
        .link_in   (links[i]),
        .link_out  (links[i+1])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      inject    <= 1'b0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_HOLD) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          inject <= in_valid && (start_time < end_time);
          if (in_valid) begin
            req_start <= start_time;
            req_end   <= end_time;
            if (start_time >= end_time) begin
              res_status <= STATUS_INVALID;
              state      <= S_HOLD;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          inject <= 1'b0;
          if (scan_done) begin
            res_status <= decision;
            if (wr_en) begin
              count <= count + CNT_BITS'(1);
            end
            state <= S_HOLD;
          end
        end
        S_HOLD: begin
          inject <= 1'b0;
          // The result waits here until the output register is free.
          if (out_free) begin
            status   <= res_status;
            accepted <= (res_status == STATUS_BOOKED);
            state    <= S_IDLE;
          end
        end
        default: begin
          inject <= 1'b0;
          state  <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/ibt_cell.sv */
// One storage cell of the booking table: holds one interval, compares it with
// the current request and passes the scan token and overlap flag onward.
// Depends on ibt_pkg.
module ibt_cell import ibt_pkg::*; #(
  parameter int TIME_BITS = 30,
  parameter int CNT_BITS  = 11,
  parameter int INDEX     = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [TIME_BITS-1:0] req_start,
  input  logic [TIME_BITS-1:0] req_end,
  input  logic [CNT_BITS-1:0]  count,
  input  logic                 wr_en,
  input  link_t                link_in,
  output link_t                link_out
);

  localparam logic [CNT_BITS-1:0] MY_INDEX = CNT_BITS'(INDEX);

  logic [TIME_BITS-1:0] cell_start;
  logic [TIME_BITS-1:0] cell_end;
  logic                 occupied;
  logic                 overlap;

  // Cells below the fill count hold booked intervals; the rest are ignored.
  assign occupied = (count > MY_INDEX);
  assign overlap  = occupied && (req_start < cell_end) && (cell_start < req_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      link_out <= '0;
    end else begin
      link_out.token <= link_in.token;
      link_out.hit   <= link_in.hit | (link_in.token & overlap);
    end
  end

  // The next free cell is the one whose index equals the fill count.
  always_ff @(posedge clk) begin
    if (wr_en && (count == MY_INDEX)) begin
      cell_start <= req_start;
      cell_end   <= req_end;
    end
  end

endmodule

/* hw/rtl/ibt_checker.sv */
// Port-level checks for the interval booking table, bound to the top level.
// Depends on ibt_pkg and interval_booking_table_top.
module ibt_checker import ibt_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    in_valid,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input logic    accepted,
  input status_t status
);

  // The accepted flag must agree with the status code.
  a_accept_matches_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (accepted == (status == STATUS_BOOKED)))
    else $error("accepted flag disagrees with status");

  // A result offered but not taken stays unchanged.
  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(accepted))
    else $error("stalled result changed");

  // Only one request is in flight, so input is closed right after a transaction.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while one is in flight");

  // No result can follow directly from reset.
  a_reset_clears_output: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind interval_booking_table_top ibt_checker u_ibt_checker (.*);
